/* design/mwrc_pkg.sv */
// ----------------------------------------------------------------------------
// mwrc_pkg: shared definitions for the write-register response checker
// Frame phase codes, status codes, register indexes, result type and the
// Modbus CRC-16 byte update.
// ----------------------------------------------------------------------------
`default_nettype none

package mwrc_pkg;

	// Configuration register indexes.
	localparam logic [1:0] CFG_SLAVE_ADDR = 2'd0;
	localparam logic [1:0] CFG_REG_ADDR   = 2'd1;

	// Result status codes.
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_CRC_ERR  = 2'd1;
	localparam logic [1:0] STATUS_REG_MISM = 2'd2;

	// Frame constants.
	localparam logic [7:0]  FUNC_WRITE_SINGLE = 8'h06;
	localparam logic [15:0] CRC_INIT          = 16'hFFFF;
	localparam logic [15:0] CRC_POLY          = 16'hA001;

	// Frame phase, one-hot.
	typedef enum logic [4:0] {
		PH_HUNT  = 5'b00001,
		PH_FUNC  = 5'b00010,
		PH_REG   = 5'b00100,
		PH_VALUE = 5'b01000,
		PH_CRC   = 5'b10000
	} phase_t;

	// One result beat from the frame parser.
	typedef struct packed {
		logic        valid;
		logic [1:0]  status;
		logic [15:0] echoed_value;
		logic [15:0] computed_crc;
	} result_beat_t;

	// Reflected CRC-16 update with one byte, all eight bit steps unrolled.
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

/* design/mwrc_parser.sv */
// ----------------------------------------------------------------------------
// mwrc_parser: frame state machine and running CRC
// Consumes one byte per step and produces at most one result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module mwrc_parser (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  step_en,
	input  wire logic [7:0]            byte_in,
	input  wire logic [7:0]            slave_addr,
	input  wire logic [15:0]           reg_addr,
	output mwrc_pkg::result_beat_t     res
);
	import mwrc_pkg::*;

	phase_t      phase_q, phase_d;
	logic        idx_q, idx_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  reg_hi_q, reg_hi_d;
	logic [15:0] value_q, value_d;
	logic [7:0]  crc_lo_q, crc_lo_d;
	logic [15:0] crc_fed;
	logic [15:0] reg_full;

	assign crc_fed  = crc_feed(crc_q, byte_in);
	assign reg_full = {reg_hi_q, byte_in};

	// Next-state and result logic for one received byte.
	always_comb begin
		phase_d  = phase_q;
		idx_d    = idx_q;
		crc_d    = crc_q;
		reg_hi_d = reg_hi_q;
		value_d  = value_q;
		crc_lo_d = crc_lo_q;
		res      = '0;
		case (phase_q)
			PH_FUNC: begin
				if (byte_in != FUNC_WRITE_SINGLE) begin
					phase_d = PH_HUNT;
					idx_d   = 1'b0;
					crc_d   = CRC_INIT;
				end else begin
					crc_d   = crc_fed;
					phase_d = PH_REG;
					idx_d   = 1'b0;
				end
			end
			PH_REG: begin
				crc_d = crc_fed;
				if (!idx_q) begin
					reg_hi_d = byte_in;
					idx_d    = 1'b1;
				end else if (reg_full != reg_addr) begin
					res.valid  = 1'b1;
					res.status = STATUS_REG_MISM;
					phase_d    = PH_HUNT;
					idx_d      = 1'b0;
					crc_d      = CRC_INIT;
				end else begin
					phase_d = PH_VALUE;
					idx_d   = 1'b0;
				end
			end
			PH_VALUE: begin
				crc_d = crc_fed;
				if (!idx_q) begin
					value_d = {byte_in, 8'h00};
					idx_d   = 1'b1;
				end else begin
					value_d = {value_q[15:8], byte_in};
					phase_d = PH_CRC;
					idx_d   = 1'b0;
				end
			end
			PH_CRC: begin
				if (!idx_q) begin
					crc_lo_d = byte_in;
					idx_d    = 1'b1;
				end else begin
					res.valid        = 1'b1;
					res.status       = ((crc_lo_q == crc_q[7:0]) && (byte_in == crc_q[15:8]))
						? STATUS_OK : STATUS_CRC_ERR;
					res.echoed_value = value_q;
					res.computed_crc = {crc_q[7:0], crc_q[15:8]};
					phase_d          = PH_HUNT;
					idx_d            = 1'b0;
					crc_d            = CRC_INIT;
				end
			end
			default: begin
				// Hunting: zero bytes and foreign addresses are skipped.
				idx_d   = 1'b0;
				crc_d   = CRC_INIT;
				phase_d = PH_HUNT;
				if ((byte_in != 8'h00) && (byte_in == slave_addr)) begin
					crc_d   = crc_feed(CRC_INIT, byte_in);
					phase_d = PH_FUNC;
				end
			end
		endcase
		if (!step_en) begin
			res = '0;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			idx_q   <= 1'b0;
			crc_q   <= CRC_INIT;
		end else if (step_en) begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			crc_q   <= crc_d;
		end
	end

	// Held frame fields.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_hi_q <= 8'h00;
			value_q  <= 16'h0000;
			crc_lo_q <= 8'h00;
		end else if (step_en) begin
			reg_hi_q <= reg_hi_d;
			value_q  <= value_d;
			crc_lo_q <= crc_lo_d;
		end
	end

endmodule

`default_nettype wire

/* design/modbus_write_register_response_check_top.sv */
// ----------------------------------------------------------------------------
// modbus_write_register_response_check_top: write-single-register response check
// Watches received bytes for a function 6 response and reports its outcome.
// ----------------------------------------------------------------------------
// Usage:
//   Received serial bytes enter one per beat on the input channel (in_valid,
//   in_stall, rx_byte). The block hunts for slave_addr, then checks function
//   code 6, the register address against reg_addr, takes the echoed value and
//   checks the CRC. A register mismatch or a complete frame gives one result
//   beat (status, echoed_value, computed_crc); other bytes give none.
//   Configuration writes on cfg_valid/cfg_ready/cfg_index/cfg_data are always
//   taken; index 0 is slave_addr, index 1 is reg_addr, others are ignored.
//   A result passes the input register, then the result register. Throughput is
//   one byte per cycle while no held result stalls the input, set by the parser
//   step with its unrolled CRC.
//   Reset puts the parser in the hunting state with slave_addr 1, reg_addr 0.
//   When the receiver stalls, the result is held; one more byte is taken into
//   the input register, after which in_stall rises until the result leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_write_register_response_check_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [15:0]      echoed_value,
	output logic [15:0]      computed_crc,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	import mwrc_pkg::*;

	logic         s1_valid;
	logic [7:0]   byte_s1;
	logic [7:0]   slave_addr_q;
	logic [15:0]  reg_addr_q;
	logic         out_free;
	logic         step_en;
	logic         out_valid_q;
	result_beat_t res;

	assign out_free  = !out_valid_q || !out_stall;
	assign step_en   = s1_valid && out_free;
	assign in_stall  = s1_valid && !out_free;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_addr_q <= 8'd1;
			reg_addr_q   <= 16'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SLAVE_ADDR: slave_addr_q <= cfg_data[7:0];
				CFG_REG_ADDR:   reg_addr_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (!in_stall) begin
			s1_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	// Frame parser.
	mwrc_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (step_en),
		.byte_in    (byte_s1),
		.slave_addr (slave_addr_q),
		.reg_addr   (reg_addr_q),
		.res        (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res.valid) begin
			status       <= res.status;
			echoed_value <= res.echoed_value;
			computed_crc <= res.computed_crc;
		end
	end

	// A result beat only comes from a parser step.
	a_res_needs_step: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> step_en)
		else $error("parser result without a step");

	// A new result is loaded only after a byte was processed.
	a_rose_after_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(step_en))
		else $error("result appeared without a processed byte");

	// Status never carries the unused code.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (status == STATUS_OK || status == STATUS_CRC_ERR ||
			status == STATUS_REG_MISM))
		else $error("invalid status code");

	// Input stalls only while a byte waits behind a held result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (s1_valid && out_valid_q && out_stall))
		else $error("input stall without a held result");

endmodule

`default_nettype wire
